FILE: hdl/cis_pkg.sv
// types, constants and microcode program of the contact impulse solver
`default_nettype none
package cis_pkg;

    localparam logic [1:0] TANGENT_ROWS = 2'd2;

    // item kinds
    localparam logic [2:0] K_WRITE   = 3'd0;
    localparam logic [2:0] K_READ    = 3'd1;
    localparam logic [2:0] K_PREPARE = 3'd2;
    localparam logic [2:0] K_SOLVE   = 3'd3;
    localparam logic [2:0] K_SETIMP  = 3'd4;

    // result sources
    localparam logic [1:0] SRC_READ = 2'd0;
    localparam logic [1:0] SRC_MASS = 2'd1;
    localparam logic [1:0] SRC_IMP  = 2'd2;

    // physical regions of the scalar store
    localparam logic [6:0] PH_JAC  = 7'd64;
    localparam logic [6:0] PH_MASS = 7'd100;
    localparam logic [6:0] PH_BIAS = 7'd103;
    localparam logic [6:0] PH_IMP  = 7'd106;

    // microcode operand addresses, temps
    localparam logic [7:0] A_RA0 = 8'd110, A_RA1 = 8'd111, A_RA2 = 8'd112;
    localparam logic [7:0] A_RB0 = 8'd113, A_RB1 = 8'd114, A_RB2 = 8'd115;
    localparam logic [7:0] A_C0 = 8'd116, A_C1 = 8'd117, A_C2 = 8'd118;
    localparam logic [7:0] A_U0 = 8'd119, A_U1 = 8'd120, A_U2 = 8'd121;
    localparam logic [7:0] A_X = 8'd122, A_Y = 8'd123, A_K = 8'd124;
    localparam logic [7:0] A_IT = 8'd125, A_SA = 8'd126, A_SB = 8'd127;
    // row relative addresses
    localparam logic [7:0] A_D0 = 8'd128, A_D1 = 8'd129, A_D2 = 8'd130;
    localparam logic [7:0] A_J0 = 8'd136, A_J1 = 8'd137, A_J2 = 8'd138;
    localparam logic [7:0] A_J3 = 8'd139, A_J4 = 8'd140, A_J5 = 8'd141;
    localparam logic [7:0] A_J6 = 8'd142, A_J7 = 8'd143, A_J8 = 8'd144;
    localparam logic [7:0] A_J9 = 8'd145, A_J10 = 8'd146, A_J11 = 8'd147;
    localparam logic [7:0] A_MASS = 8'd160, A_BIAS = 8'd161;
    localparam logic [7:0] A_IMP = 8'd162, A_RES = 8'd163;
    localparam logic [7:0] A_NONE = 8'd0;

    // program entry and branch points
    localparam logic [7:0] PC_PREP  = 8'd0;
    localparam logic [7:0] PC_TBIAS = 8'd70;
    localparam logic [7:0] PC_KMASS = 8'd71;
    localparam logic [7:0] PC_SOLVE = 8'd118;
    localparam logic [7:0] PC_FRIC  = 8'd148;
    localparam logic [7:0] PC_DELTA = 8'd151;
    localparam logic [7:0] PC_APPLY = 8'd153;
    localparam logic [7:0] PC_LAST  = 8'd209;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_NEG, OP_MOV, OP_NGT, OP_SELF, OP_MAX0,
        OP_CLMP, OP_RCP, OP_JMP, OP_BRT, OP_END, OP_ENDNW
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_RDB, S_EXE, S_DIV, S_WB, S_FIN, S_OUT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] dst;
        logic [7:0] a;
        logic [7:0] b;
    } uop_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [63:0] prod;
        logic               flag;
    } alu_in_t;

    function automatic uop_t mk(op_t o, logic [7:0] d, logic [7:0] a, logic [7:0] b);
        uop_t u;
        u.op = o;
        u.dst = d;
        u.a = a;
        u.b = b;
        return u;
    endfunction

    function automatic uop_t ucode(logic [7:0] pc);
        uop_t u;
        case (pc)
            // lever arms
            8'd0: u = mk(OP_SUB, A_RA0, 8'd41, 8'd32);
            8'd1: u = mk(OP_SUB, A_RA1, 8'd42, 8'd33);
            8'd2: u = mk(OP_SUB, A_RA2, 8'd43, 8'd34);
            8'd3: u = mk(OP_SUB, A_RB0, 8'd41, 8'd35);
            8'd4: u = mk(OP_SUB, A_RB1, 8'd42, 8'd36);
            8'd5: u = mk(OP_SUB, A_RB2, 8'd43, 8'd37);
            // ra x dir
            8'd6: u = mk(OP_MUL, A_X, A_RA1, A_D2);
            8'd7: u = mk(OP_MUL, A_Y, A_RA2, A_D1);
            8'd8: u = mk(OP_SUB, A_C0, A_X, A_Y);
            8'd9: u = mk(OP_MUL, A_X, A_RA2, A_D0);
            8'd10: u = mk(OP_MUL, A_Y, A_RA0, A_D2);
            8'd11: u = mk(OP_SUB, A_C1, A_X, A_Y);
            8'd12: u = mk(OP_MUL, A_X, A_RA0, A_D1);
            8'd13: u = mk(OP_MUL, A_Y, A_RA1, A_D0);
            8'd14: u = mk(OP_SUB, A_C2, A_X, A_Y);
            // jacobian
            8'd15: u = mk(OP_NEG, A_J0, A_D0, A_NONE);
            8'd16: u = mk(OP_NEG, A_J1, A_D1, A_NONE);
            8'd17: u = mk(OP_NEG, A_J2, A_D2, A_NONE);
            8'd18: u = mk(OP_NEG, A_J3, A_C0, A_NONE);
            8'd19: u = mk(OP_NEG, A_J4, A_C1, A_NONE);
            8'd20: u = mk(OP_NEG, A_J5, A_C2, A_NONE);
            8'd21: u = mk(OP_MOV, A_J6, A_D0, A_NONE);
            8'd22: u = mk(OP_MOV, A_J7, A_D1, A_NONE);
            8'd23: u = mk(OP_MOV, A_J8, A_D2, A_NONE);
            8'd24: u = mk(OP_MUL, A_X, A_RB1, A_D2);
            8'd25: u = mk(OP_MUL, A_Y, A_RB2, A_D1);
            8'd26: u = mk(OP_SUB, A_J9, A_X, A_Y);
            8'd27: u = mk(OP_MUL, A_X, A_RB2, A_D0);
            8'd28: u = mk(OP_MUL, A_Y, A_RB0, A_D2);
            8'd29: u = mk(OP_SUB, A_J10, A_X, A_Y);
            8'd30: u = mk(OP_MUL, A_X, A_RB0, A_D1);
            8'd31: u = mk(OP_MUL, A_Y, A_RB1, A_D0);
            8'd32: u = mk(OP_SUB, A_J11, A_X, A_Y);
            8'd33: u = mk(OP_BRT, PC_TBIAS, A_NONE, A_NONE);
            // normal row bias: wb x rb, wa x ra
            8'd34: u = mk(OP_MUL, A_X, 8'd10, A_RB2);
            8'd35: u = mk(OP_MUL, A_Y, 8'd11, A_RB1);
            8'd36: u = mk(OP_SUB, A_U0, A_X, A_Y);
            8'd37: u = mk(OP_MUL, A_X, 8'd11, A_RB0);
            8'd38: u = mk(OP_MUL, A_Y, 8'd9, A_RB2);
            8'd39: u = mk(OP_SUB, A_U1, A_X, A_Y);
            8'd40: u = mk(OP_MUL, A_X, 8'd9, A_RB1);
            8'd41: u = mk(OP_MUL, A_Y, 8'd10, A_RB0);
            8'd42: u = mk(OP_SUB, A_U2, A_X, A_Y);
            8'd43: u = mk(OP_MUL, A_X, 8'd4, A_RA2);
            8'd44: u = mk(OP_MUL, A_Y, 8'd5, A_RA1);
            8'd45: u = mk(OP_SUB, A_C0, A_X, A_Y);
            8'd46: u = mk(OP_MUL, A_X, 8'd5, A_RA0);
            8'd47: u = mk(OP_MUL, A_Y, 8'd3, A_RA2);
            8'd48: u = mk(OP_SUB, A_C1, A_X, A_Y);
            8'd49: u = mk(OP_MUL, A_X, 8'd3, A_RA1);
            8'd50: u = mk(OP_MUL, A_Y, 8'd4, A_RA0);
            8'd51: u = mk(OP_SUB, A_C2, A_X, A_Y);
            8'd52: u = mk(OP_ADD, A_X, 8'd6, A_U0);
            8'd53: u = mk(OP_ADD, A_Y, 8'd0, A_C0);
            8'd54: u = mk(OP_SUB, A_U0, A_X, A_Y);
            8'd55: u = mk(OP_ADD, A_X, 8'd7, A_U1);
            8'd56: u = mk(OP_ADD, A_Y, 8'd1, A_C1);
            8'd57: u = mk(OP_SUB, A_U1, A_X, A_Y);
            8'd58: u = mk(OP_ADD, A_X, 8'd8, A_U2);
            8'd59: u = mk(OP_ADD, A_Y, 8'd2, A_C2);
            8'd60: u = mk(OP_SUB, A_U2, A_X, A_Y);
            8'd61: u = mk(OP_MUL, A_X, A_D0, A_U0);
            8'd62: u = mk(OP_MUL, A_Y, A_D1, A_U1);
            8'd63: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd64: u = mk(OP_MUL, A_Y, A_D2, A_U2);
            8'd65: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd66: u = mk(OP_NGT, A_NONE, A_X, 8'd51);
            8'd67: u = mk(OP_MUL, A_Y, 8'd50, A_X);
            8'd68: u = mk(OP_SELF, A_BIAS, A_Y, A_NONE);
            8'd69: u = mk(OP_JMP, PC_KMASS, A_NONE, A_NONE);
            // tangent row bias
            8'd70: u = mk(OP_NEG, A_BIAS, 8'd53, A_NONE);
            // k, body a
            8'd71: u = mk(OP_MUL, A_X, 8'd14, A_J3);
            8'd72: u = mk(OP_MUL, A_Y, 8'd15, A_J4);
            8'd73: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd74: u = mk(OP_MUL, A_Y, 8'd16, A_J5);
            8'd75: u = mk(OP_ADD, A_C0, A_X, A_Y);
            8'd76: u = mk(OP_MUL, A_X, 8'd17, A_J3);
            8'd77: u = mk(OP_MUL, A_Y, 8'd18, A_J4);
            8'd78: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd79: u = mk(OP_MUL, A_Y, 8'd19, A_J5);
            8'd80: u = mk(OP_ADD, A_C1, A_X, A_Y);
            8'd81: u = mk(OP_MUL, A_X, 8'd20, A_J3);
            8'd82: u = mk(OP_MUL, A_Y, 8'd21, A_J4);
            8'd83: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd84: u = mk(OP_MUL, A_Y, 8'd22, A_J5);
            8'd85: u = mk(OP_ADD, A_C2, A_X, A_Y);
            8'd86: u = mk(OP_MUL, A_X, A_J3, A_C0);
            8'd87: u = mk(OP_MUL, A_Y, A_J4, A_C1);
            8'd88: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd89: u = mk(OP_MUL, A_Y, A_J5, A_C2);
            8'd90: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd91: u = mk(OP_ADD, A_K, 8'd12, A_X);
            8'd92: u = mk(OP_ADD, A_K, A_K, 8'd13);
            // k, body b
            8'd93: u = mk(OP_MUL, A_X, 8'd23, A_J9);
            8'd94: u = mk(OP_MUL, A_Y, 8'd24, A_J10);
            8'd95: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd96: u = mk(OP_MUL, A_Y, 8'd25, A_J11);
            8'd97: u = mk(OP_ADD, A_C0, A_X, A_Y);
            8'd98: u = mk(OP_MUL, A_X, 8'd26, A_J9);
            8'd99: u = mk(OP_MUL, A_Y, 8'd27, A_J10);
            8'd100: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd101: u = mk(OP_MUL, A_Y, 8'd28, A_J11);
            8'd102: u = mk(OP_ADD, A_C1, A_X, A_Y);
            8'd103: u = mk(OP_MUL, A_X, 8'd29, A_J9);
            8'd104: u = mk(OP_MUL, A_Y, 8'd30, A_J10);
            8'd105: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd106: u = mk(OP_MUL, A_Y, 8'd31, A_J11);
            8'd107: u = mk(OP_ADD, A_C2, A_X, A_Y);
            8'd108: u = mk(OP_MUL, A_X, A_J9, A_C0);
            8'd109: u = mk(OP_MUL, A_Y, A_J10, A_C1);
            8'd110: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd111: u = mk(OP_MUL, A_Y, A_J11, A_C2);
            8'd112: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd113: u = mk(OP_ADD, A_K, A_K, A_X);
            8'd114: u = mk(OP_RCP, A_MASS, A_K, A_NONE);
            8'd115: u = mk(OP_ENDNW, A_NONE, A_RES, A_NONE);
            8'd116: u = mk(OP_MOV, A_IT, A_IMP, A_NONE);
            8'd117: u = mk(OP_JMP, PC_APPLY, A_NONE, A_NONE);
            // solve: j . v
            8'd118: u = mk(OP_MUL, A_X, A_J0, 8'd0);
            8'd119: u = mk(OP_MUL, A_Y, A_J1, 8'd1);
            8'd120: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd121: u = mk(OP_MUL, A_Y, A_J2, 8'd2);
            8'd122: u = mk(OP_ADD, A_K, A_X, A_Y);
            8'd123: u = mk(OP_MUL, A_X, A_J3, 8'd3);
            8'd124: u = mk(OP_MUL, A_Y, A_J4, 8'd4);
            8'd125: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd126: u = mk(OP_MUL, A_Y, A_J5, 8'd5);
            8'd127: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd128: u = mk(OP_ADD, A_K, A_K, A_X);
            8'd129: u = mk(OP_MUL, A_X, A_J6, 8'd6);
            8'd130: u = mk(OP_MUL, A_Y, A_J7, 8'd7);
            8'd131: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd132: u = mk(OP_MUL, A_Y, A_J8, 8'd8);
            8'd133: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd134: u = mk(OP_ADD, A_K, A_K, A_X);
            8'd135: u = mk(OP_MUL, A_X, A_J9, 8'd9);
            8'd136: u = mk(OP_MUL, A_Y, A_J10, 8'd10);
            8'd137: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd138: u = mk(OP_MUL, A_Y, A_J11, 8'd11);
            8'd139: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd140: u = mk(OP_ADD, A_K, A_K, A_X);
            8'd141: u = mk(OP_ADD, A_K, A_K, A_BIAS);
            8'd142: u = mk(OP_NEG, A_K, A_K, A_NONE);
            8'd143: u = mk(OP_MUL, A_X, A_MASS, A_K);
            8'd144: u = mk(OP_ADD, A_Y, A_IMP, A_X);
            8'd145: u = mk(OP_BRT, PC_FRIC, A_NONE, A_NONE);
            8'd146: u = mk(OP_MAX0, A_Y, A_Y, A_NONE);
            8'd147: u = mk(OP_JMP, PC_DELTA, A_NONE, A_NONE);
            8'd148: u = mk(OP_MUL, A_X, 8'd52, 8'd106);
            8'd149: u = mk(OP_MAX0, A_X, A_X, A_NONE);
            8'd150: u = mk(OP_CLMP, A_Y, A_Y, A_X);
            8'd151: u = mk(OP_SUB, A_IT, A_Y, A_IMP);
            8'd152: u = mk(OP_MOV, A_IMP, A_Y, A_NONE);
            // apply impulse held in A_IT
            8'd153: u = mk(OP_MUL, A_SA, 8'd12, A_IT);
            8'd154: u = mk(OP_MUL, A_SB, 8'd13, A_IT);
            8'd155: u = mk(OP_MUL, A_X, A_J0, A_SA);
            8'd156: u = mk(OP_ADD, 8'd0, 8'd0, A_X);
            8'd157: u = mk(OP_MUL, A_X, A_J1, A_SA);
            8'd158: u = mk(OP_ADD, 8'd1, 8'd1, A_X);
            8'd159: u = mk(OP_MUL, A_X, A_J2, A_SA);
            8'd160: u = mk(OP_ADD, 8'd2, 8'd2, A_X);
            8'd161: u = mk(OP_MUL, A_X, A_J6, A_SB);
            8'd162: u = mk(OP_ADD, 8'd6, 8'd6, A_X);
            8'd163: u = mk(OP_MUL, A_X, A_J7, A_SB);
            8'd164: u = mk(OP_ADD, 8'd7, 8'd7, A_X);
            8'd165: u = mk(OP_MUL, A_X, A_J8, A_SB);
            8'd166: u = mk(OP_ADD, 8'd8, 8'd8, A_X);
            8'd167: u = mk(OP_MUL, A_X, 8'd14, A_J3);
            8'd168: u = mk(OP_MUL, A_Y, 8'd15, A_J4);
            8'd169: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd170: u = mk(OP_MUL, A_Y, 8'd16, A_J5);
            8'd171: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd172: u = mk(OP_MUL, A_X, A_X, A_IT);
            8'd173: u = mk(OP_ADD, 8'd3, 8'd3, A_X);
            8'd174: u = mk(OP_MUL, A_X, 8'd17, A_J3);
            8'd175: u = mk(OP_MUL, A_Y, 8'd18, A_J4);
            8'd176: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd177: u = mk(OP_MUL, A_Y, 8'd19, A_J5);
            8'd178: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd179: u = mk(OP_MUL, A_X, A_X, A_IT);
            8'd180: u = mk(OP_ADD, 8'd4, 8'd4, A_X);
            8'd181: u = mk(OP_MUL, A_X, 8'd20, A_J3);
            8'd182: u = mk(OP_MUL, A_Y, 8'd21, A_J4);
            8'd183: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd184: u = mk(OP_MUL, A_Y, 8'd22, A_J5);
            8'd185: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd186: u = mk(OP_MUL, A_X, A_X, A_IT);
            8'd187: u = mk(OP_ADD, 8'd5, 8'd5, A_X);
            8'd188: u = mk(OP_MUL, A_X, 8'd23, A_J9);
            8'd189: u = mk(OP_MUL, A_Y, 8'd24, A_J10);
            8'd190: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd191: u = mk(OP_MUL, A_Y, 8'd25, A_J11);
            8'd192: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd193: u = mk(OP_MUL, A_X, A_X, A_IT);
            8'd194: u = mk(OP_ADD, 8'd9, 8'd9, A_X);
            8'd195: u = mk(OP_MUL, A_X, 8'd26, A_J9);
            8'd196: u = mk(OP_MUL, A_Y, 8'd27, A_J10);
            8'd197: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd198: u = mk(OP_MUL, A_Y, 8'd28, A_J11);
            8'd199: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd200: u = mk(OP_MUL, A_X, A_X, A_IT);
            8'd201: u = mk(OP_ADD, 8'd10, 8'd10, A_X);
            8'd202: u = mk(OP_MUL, A_X, 8'd29, A_J9);
            8'd203: u = mk(OP_MUL, A_Y, 8'd30, A_J10);
            8'd204: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd205: u = mk(OP_MUL, A_Y, 8'd31, A_J11);
            8'd206: u = mk(OP_ADD, A_X, A_X, A_Y);
            8'd207: u = mk(OP_MUL, A_X, A_X, A_IT);
            8'd208: u = mk(OP_ADD, 8'd11, 8'd11, A_X);
            8'd209: u = mk(OP_END, A_NONE, A_RES, A_NONE);
            default: u = mk(OP_END, A_NONE, A_RES, A_NONE);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/cis_if.sv
// item channel interfaces of the contact impulse solver
`default_nettype none
interface cis_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [1:0]         row;
    logic [5:0]         slot;
    logic signed [31:0] value;
    modport source (output valid, kind, row, slot, value, input ready);
    modport sink (input valid, kind, row, slot, value, output ready);
endinterface

interface cis_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [1:0]         result_source;
    modport source (output valid, result_value, result_source, input ready);
    modport sink (input valid, result_value, result_source, output ready);
endinterface
`default_nettype wire

FILE: hdl/cis_alu.sv
// shared saturating q-format arithmetic unit
`default_nettype none
module cis_alu
    import cis_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  alu_in_t            req,
    output logic signed [31:0] result,
    output logic               flag
);

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [31:0] QMAX = 32'sh7fffffff;
    localparam logic signed [31:0] QMIN = 32'sh80000000;

    logic signed [32:0] sum;
    logic signed [32:0] dif;
    logic signed [32:0] ng;
    logic signed [63:0] rnd;
    logic signed [63:0] shf;
    logic signed [31:0] sum_s;
    logic signed [31:0] dif_s;
    logic signed [31:0] ng_s;
    logic signed [31:0] mul_s;
    logic signed [31:0] nb;

    function automatic logic signed [31:0] sat33(logic signed [32:0] x);
        logic signed [31:0] r;
        if (x[32] != x[31])
        begin
            r = x[32] ? QMIN : QMAX;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    always_comb
    begin
        sum   = {req.a[31], req.a} + {req.b[31], req.b};
        dif   = {req.a[31], req.a} - {req.b[31], req.b};
        ng    = 33'sd0 - {req.a[31], req.a};
        sum_s = sat33(sum);
        dif_s = sat33(dif);
        ng_s  = sat33(ng);
        rnd   = req.prod + HALF;
        shf   = rnd >>> FRAC_BITS;
        if (shf > 64'sd2147483647)
        begin
            mul_s = QMAX;
        end
        else if (shf < -64'sd2147483648)
        begin
            mul_s = QMIN;
        end
        else
        begin
            mul_s = shf[31:0];
        end
        // b is a non-negative limit here
        nb   = -req.b;
        flag = req.flag;
        case (req.op)
            OP_ADD:  result = sum_s;
            OP_SUB:  result = dif_s;
            OP_MUL:  result = mul_s;
            OP_NEG:  result = ng_s;
            OP_MOV:  result = req.a;
            OP_SELF: result = req.flag ? req.a : 32'sd0;
            OP_MAX0: result = req.a[31] ? 32'sd0 : req.a;
            OP_CLMP:
            begin
                if (req.a < nb)
                begin
                    result = nb;
                end
                else if (req.a > req.b)
                begin
                    result = req.b;
                end
                else
                begin
                    result = req.a;
                end
            end
            OP_NGT:
            begin
                result = 32'sd0;
                flag   = ng_s > req.b;
            end
            default: result = req.a;
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/cis_recip.sv
// bit-serial restoring reciprocal of k in q format
`default_nettype none
module cis_recip
    import cis_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] divisor,
    output logic               done,
    output logic signed [31:0] quotient
);

    localparam int QW = 2 * FRAC_BITS + 1;
    localparam int CW = $clog2(QW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic          nonpos_reg, nonpos_next;
    logic [31:0]   dvs_reg, dvs_next;
    logic [32:0]   rem_reg, rem_next;
    logic [QW-1:0] q_reg, q_next;
    logic [32:0]   trial;
    logic [63:0]   q_wide;

    always_comb
    begin
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        nonpos_next = nonpos_reg;
        dvs_next    = dvs_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        // dividend is a single one at bit 2*frac, shifted in first
        trial = {rem_reg[31:0], (cnt_reg == CW'(QW))};
        if (start)
        begin
            cnt_next    = CW'(QW);
            nonpos_next = (divisor <= 32'sd0);
            dvs_next    = divisor;
            rem_next    = '0;
            q_next      = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nonpos_reg <= nonpos_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
    end

    always_comb
    begin
        q_wide = {{(64 - QW){1'b0}}, q_reg};
        if (nonpos_reg)
        begin
            quotient = 32'sd0;
        end
        else if (q_wide > 64'h7fffffff)
        begin
            quotient = 32'sh7fffffff;
        end
        else
        begin
            quotient = q_wide[31:0];
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire

FILE: hdl/contact_impulse_solver_core.sv
// top level: microcoded contact impulse solver around one shared alu
// write and set-impulse items finish on accept; read results pass finish and output states
// prepare: 111 alu microops for a normal row, each in fetch, read, execute and writeback,
// plus branches and a reciprocal step; tangent rows use a shorter bias step, and warm start
// also applies the impulse; solve: 86 alu microops plus branches normal row, 88 friction row
// items are taken one at a time, only while the sequencer is idle
// reset: store and row state read as zero via per-entry valid bits, warm start on
`default_nettype none
module contact_impulse_solver_core
    import cis_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    cis_in_if.sink           in_ch,
    cis_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // sequencer state
    state_t     state_reg, state_next;
    logic [7:0] pc_reg, pc_next;
    logic       prep_reg;
    logic [1:0] row_reg;
    logic       flag_reg;
    logic       warm_reg;

    // operand path
    logic signed [31:0] opa_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] res_reg;
    logic [1:0]         src_reg;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] out_val_reg;
    logic [1:0]         out_src_reg;

    // scalar store: operands, jacobians, row values and temps
    logic [31:0]  mem [0:127];
    logic [127:0] valid_reg;
    logic [31:0]  rd_data_reg;
    logic         rd_ok_reg;
    logic signed [31:0] rdval;

    uop_t       uop;
    logic [6:0] raddr;
    logic       we;
    logic [6:0] waddr;
    logic [31:0] wdata;

    logic       accept;
    logic       row_ok;
    logic       out_free;
    logic       cfg_wr;

    alu_in_t            alu_req;
    logic signed [31:0] alu_res;
    logic               alu_flag;
    logic               rcp_start;
    logic               rcp_done;
    logic signed [31:0] rcp_q;

    // map a microcode address onto the store for the active row
    function automatic logic [6:0] phys(logic [7:0] v, logic [1:0] r, logic prep);
        logic [6:0] dbase;
        logic [6:0] jbase;
        logic [6:0] p;
        case (r)
            2'd0:    dbase = 7'd38;
            2'd1:    dbase = 7'd44;
            default: dbase = 7'd47;
        endcase
        case (r)
            2'd0:    jbase = PH_JAC;
            2'd1:    jbase = PH_JAC + 7'd12;
            default: jbase = PH_JAC + 7'd24;
        endcase
        if (!v[7])
        begin
            p = v[6:0];
        end
        else if (v < A_J0)
        begin
            p = dbase + {5'd0, v[1:0]};
        end
        else if (v < A_MASS)
        begin
            p = jbase + 7'(v - A_J0);
        end
        else
        begin
            case (v)
                A_MASS:  p = PH_MASS + {5'd0, r};
                A_BIAS:  p = PH_BIAS + {5'd0, r};
                A_IMP:   p = PH_IMP + {5'd0, r};
                default: p = prep ? PH_MASS + {5'd0, r} : PH_IMP + {5'd0, r};
            endcase
        end
        return p;
    endfunction

    assign uop      = ucode(pc_reg);
    assign accept   = in_ch.valid && in_ch.ready;
    assign row_ok   = in_ch.row <= TANGENT_ROWS;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign rdval    = rd_ok_reg ? $signed(rd_data_reg) : 32'sd0;

    assign in_ch.ready          = (state_reg == S_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.result_value  = out_val_reg;
    assign out_ch.result_source = out_src_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, warm_reg} : 32'd0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.kind == K_READ)
                    begin
                        state_next = S_FIN;
                    end
                    else if (in_ch.kind == K_PREPARE && row_ok)
                    begin
                        state_next = S_FETCH;
                        pc_next    = PC_PREP;
                    end
                    else if (in_ch.kind == K_SOLVE && row_ok)
                    begin
                        state_next = S_FETCH;
                        pc_next    = PC_SOLVE;
                    end
                end
            end
            S_FETCH:
            begin
                case (uop.op)
                    OP_JMP: pc_next = uop.dst;
                    OP_BRT: pc_next = (row_reg != 2'd0) ? uop.dst : pc_reg + 8'd1;
                    OP_END: state_next = S_FIN;
                    OP_ENDNW:
                    begin
                        if (warm_reg)
                        begin
                            pc_next = pc_reg + 8'd1;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    default: state_next = S_RDB;
                endcase
            end
            S_RDB: state_next = S_EXE;
            S_EXE: state_next = (uop.op == OP_RCP) ? S_DIV : S_WB;
            S_DIV:
            begin
                if (rcp_done)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                state_next = S_FETCH;
                pc_next    = pc_reg + 8'd1;
            end
            S_FIN: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // store port selection, operand b is held on the read port through writeback
    always_comb
    begin
        case (state_reg)
            S_IDLE:       raddr = {1'b0, in_ch.slot};
            S_RDB, S_EXE: raddr = phys(uop.b, row_reg, prep_reg);
            default:      raddr = phys(uop.a, row_reg, prep_reg);
        endcase
        we    = 1'b0;
        waddr = phys(uop.dst, row_reg, prep_reg);
        wdata = alu_res;
        if (state_reg == S_IDLE)
        begin
            waddr = {1'b0, in_ch.slot};
            wdata = in_ch.value;
            if (accept && in_ch.kind == K_WRITE)
            begin
                we = 1'b1;
            end
            else if (accept && in_ch.kind == K_SETIMP && row_ok)
            begin
                we    = 1'b1;
                waddr = PH_IMP + {5'd0, in_ch.row};
            end
        end
        else if (state_reg == S_WB && uop.op != OP_NGT)
        begin
            we    = 1'b1;
            wdata = (uop.op == OP_RCP) ? rcp_q : alu_res;
        end
    end

    always_comb
    begin
        alu_req.op   = uop.op;
        alu_req.a    = opa_reg;
        alu_req.b    = rdval;
        alu_req.prod = prod_reg;
        alu_req.flag = flag_reg;
    end

    assign rcp_start = (state_reg == S_EXE) && (uop.op == OP_RCP);

    cis_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .req    (alu_req),
        .result (alu_res),
        .flag   (alu_flag)
    );

    cis_recip #(
        .FRAC_BITS (FRAC_BITS)
    ) u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rcp_start),
        .divisor  (opa_reg),
        .done     (rcp_done),
        .quotient (rcp_q)
    );

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_ok_reg <= valid_reg[raddr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= PC_PREP;
            warm_reg      <= 1'b1;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (cfg_wr)
            begin
                warm_reg <= pwdata[0];
            end
            if (state_reg == S_WB && uop.op == OP_NGT)
            begin
                flag_reg <= alu_flag;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg  <= in_ch.row;
            prep_reg <= (in_ch.kind == K_PREPARE);
            if (in_ch.kind == K_READ)
            begin
                src_reg <= SRC_READ;
            end
            else if (in_ch.kind == K_PREPARE)
            begin
                src_reg <= SRC_MASS;
            end
            else
            begin
                src_reg <= SRC_IMP;
            end
        end
        if (state_reg == S_RDB)
        begin
            opa_reg <= rdval;
        end
        if (state_reg == S_EXE)
        begin
            prod_reg <= opa_reg * rdval;
        end
        if (state_reg == S_FIN)
        begin
            res_reg <= rdval;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_val_reg <= res_reg;
            out_src_reg <= src_reg;
        end
    end

    // the program never runs past its last microop
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |-> pc_reg <= PC_LAST)
        else $error("microcode pc out of range");

    // reciprocal finishes only while the sequencer waits on it
    a_rcp_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rcp_done |-> state_reg == S_DIV)
        else $error("reciprocal done outside wait state");

    // a new result comes only from the output stage
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside output stage");

    // store writes come from accepted items or writeback only
    a_we_src: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (accept || state_reg == S_WB))
        else $error("store write without a source");

endmodule
`default_nettype wire
